/* rtl/otrip_pkg.sv */
// Shared types, constants and opcodes for the odometer and trip accumulator.
package otrip_pkg;

    // Fixed-point and unit settings
    localparam int FRAC_BITS   = 16;
    localparam int STEP_METRES = 100;
    localparam int KM_METRES   = 1000;
    localparam int TICK_DIV    = 360;

    // Field widths
    localparam int SPEED_W   = 16;
    localparam int ELAPSED_W = 10;
    localparam int EXTRA_W   = 8;
    localparam int LOAD_W    = 32;
    localparam int TRIP_W    = 16;
    localparam int ODO_W     = 32;
    localparam int CNT_W     = 32;
    localparam int ACC_W     = 48;

    // Stream widths
    localparam int OP_W         = 3;
    localparam int IN_FIELDS_W  = SPEED_W + ELAPSED_W + 1 + EXTRA_W + LOAD_W;
    localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = 2 * TRIP_W + ODO_W + 2 * CNT_W + 2;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;
    localparam int CFG_DATA_W   = 32;

    // Distance: (p << FRAC_BITS) / 360 = p * DQ + (p * DR) / 360, p = speed * elapsed
    localparam int P_W       = SPEED_W + ELAPSED_W;
    localparam int DQ        = (1 << FRAC_BITS) / TICK_DIV;
    localparam int DR        = (1 << FRAC_BITS) % TICK_DIV;
    localparam int DQ_W      = $clog2(DQ + 1);
    localparam int DR_W      = $clog2(DR + 1);
    localparam int HI_W      = P_W + DQ_W;
    localparam int Y_W       = P_W + DR_W;
    // reciprocal error stays below 360 < 2^9, so the floor is exact for y < 2^Y_W
    localparam int RCP_SHIFT = Y_W + 9;
    localparam longint unsigned RCP =
        ((64'd1 << RCP_SHIFT) + TICK_DIV - 1) / TICK_DIV;
    localparam int RCP_W     = RCP_SHIFT - 8;
    localparam int LO_W      = Y_W - 8;
    localparam int D_W       = P_W + FRAC_BITS - 8;

    // Extra hundreds term
    localparam int STEP_W = $clog2(STEP_METRES + 1);
    localparam int EXTM_W = EXTRA_W + STEP_W;

    // Remainder of a loaded trip value modulo the km/step ratio
    localparam int RATIO_RAW = KM_METRES / STEP_METRES;
    localparam int RATIO     = (RATIO_RAW == 0) ? 1 : RATIO_RAW;
    localparam int RAT_L     = $clog2(RATIO);
    localparam int LD_SHIFT  = LOAD_W + RAT_L;
    localparam longint unsigned LD_RCP =
        ((64'd1 << LD_SHIFT) + RATIO - 1) / RATIO;
    localparam int LD_RCP_W  = LOAD_W + 1;
    localparam int REM_W     = (RAT_L > 0) ? RAT_L : 1;

    // Fixed-point thresholds and limits
    localparam logic [ACC_W-1:0] STEP_FX = ACC_W'(STEP_METRES) << FRAC_BITS;
    localparam logic [ACC_W-1:0] KM_FX   = ACC_W'(KM_METRES) << FRAC_BITS;
    localparam logic [ACC_W-1:0] ACC_MAX = '1;
    localparam logic [CNT_W-1:0] AVG_MAX = {{(CNT_W-1){1'b1}}, 1'b0};
    localparam logic [ODO_W-1:0] ODO_INVALID = '1;

    // Reset values of the configuration registers
    localparam logic [TRIP_W-1:0] TRIP_LIMIT_RST = TRIP_W'(10000);
    localparam logic [ODO_W-1:0]  ODO_LIMIT_RST  = ODO_W'(999999);

    typedef enum logic [OP_W-1:0] {
        OP_TICK       = 3'd0,
        OP_CLR_TRIP1  = 3'd1,
        OP_CLR_TRIP2  = 3'd2,
        OP_CLR_ODO    = 3'd3,
        OP_LOAD_ODO   = 3'd4,
        OP_LOAD_TRIP1 = 3'd5,
        OP_LOAD_TRIP2 = 3'd6
    } t_opcode;

    typedef enum logic [0:0] {
        CFG_TRIP_LIMIT = 1'b0,
        CFG_ODO_LIMIT  = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        t_opcode                opcode;
        logic [SPEED_W-1:0]     speed;
        logic [ELAPSED_W-1:0]   elapsed;
        logic                   ign;
        logic [EXTRA_W-1:0]     extra;
        logic [LOAD_W-1:0]      load;
    } t_req;

    typedef struct packed {
        t_opcode            opcode;
        logic               moving;
        logic [LOAD_W-1:0]  load;
    } t_ctl;

    typedef struct packed {
        t_opcode            opcode;
        logic               moving;
        logic [LOAD_W-1:0]  load;
        logic [D_W-1:0]     dist_fx;
        logic [ACC_W-1:0]   dist_ext;
        logic [ACC_W-1:0]   rest;
    } t_work;

    typedef struct packed {
        logic [TRIP_W-1:0]  trip_one;
        logic [TRIP_W-1:0]  trip_two;
        logic [ODO_W-1:0]   odometer_km;
        logic [CNT_W-1:0]   fuel_avg_distance;
        logic [CNT_W-1:0]   this_trip_distance;
        logic               trip_store_request;
        logic               odo_store_request;
    } t_result;

endpackage

/* rtl/otrip_dist.sv */
// Distance pipeline: input register, speed*time product, constant division by 360.
module otrip_dist
    import otrip_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  t_req    i_req,
    output logic    o_ready,
    output logic    o_valid,
    output t_work   o_work,
    input  logic    i_ready
);

    logic rdy_a, rdy_b, rdy_c, rdy_d, rdy_e;

    logic r_a_v, r_b_v, r_c_v, r_d_v, r_e_v;

    t_req                   r_a_req;

    t_ctl                   r_b_ctl;
    logic [P_W-1:0]         r_b_prod;
    logic [EXTM_W-1:0]      r_b_extm;
    logic [LOAD_W-1:0]      r_b_quo;

    t_ctl                   r_c_ctl;
    logic [HI_W-1:0]        r_c_hi;
    logic [Y_W-1:0]         r_c_y;
    logic [EXTM_W-1:0]      r_c_extm;
    logic [REM_W-1:0]       r_c_rem;

    t_ctl                   r_d_ctl;
    logic [HI_W-1:0]        r_d_hi;
    logic [LO_W-1:0]        r_d_lo;
    logic [EXTM_W-1:0]      r_d_extm;
    logic [ACC_W-1:0]       r_d_rest;

    t_work                  r_e_work;

    logic [LOAD_W+LD_RCP_W-1:0] quo_full;
    logic [LOAD_W-1:0]          rem_full;
    logic [Y_W+RCP_W-1:0]       lo_full;
    logic [ACC_W-1:0]           dist_sum;

    // a stage takes new data when it is empty or its contents move on
    assign rdy_e   = !r_e_v || i_ready;
    assign rdy_d   = !r_d_v || rdy_e;
    assign rdy_c   = !r_c_v || rdy_d;
    assign rdy_b   = !r_b_v || rdy_c;
    assign rdy_a   = !r_a_v || rdy_b;
    assign o_ready = rdy_a;
    assign o_valid = r_e_v;
    assign o_work  = r_e_work;

    assign quo_full = (LOAD_W+LD_RCP_W)'(r_a_req.load) * (LOAD_W+LD_RCP_W)'(LD_RCP);
    assign rem_full = r_b_ctl.load - LOAD_W'(r_b_quo * LOAD_W'(RATIO));
    assign lo_full  = (Y_W+RCP_W)'(r_c_y) * (Y_W+RCP_W)'(RCP);
    assign dist_sum = ACC_W'(r_d_hi) + ACC_W'(r_d_lo);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
            r_c_v <= 1'b0;
            r_d_v <= 1'b0;
            r_e_v <= 1'b0;
        end else begin
            if (rdy_a) r_a_v <= i_valid;
            if (rdy_b) r_b_v <= r_a_v;
            if (rdy_c) r_c_v <= r_b_v;
            if (rdy_d) r_d_v <= r_c_v;
            if (rdy_e) r_e_v <= r_d_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy_a) begin
            r_a_req <= i_req;
        end
        if (rdy_b) begin
            r_b_ctl.opcode <= r_a_req.opcode;
            r_b_ctl.moving <= r_a_req.ign && (r_a_req.speed != '0);
            r_b_ctl.load   <= r_a_req.load;
            r_b_prod       <= P_W'(r_a_req.speed) * P_W'(r_a_req.elapsed);
            r_b_extm       <= EXTM_W'(r_a_req.extra) * EXTM_W'(STEP_METRES);
            r_b_quo        <= LOAD_W'(quo_full >> LD_SHIFT);
        end
        if (rdy_c) begin
            r_c_ctl  <= r_b_ctl;
            r_c_hi   <= HI_W'(r_b_prod) * HI_W'(DQ);
            r_c_y    <= Y_W'(r_b_prod) * Y_W'(DR);
            r_c_extm <= r_b_extm;
            r_c_rem  <= rem_full[REM_W-1:0];
        end
        if (rdy_d) begin
            r_d_ctl  <= r_c_ctl;
            r_d_hi   <= r_c_hi;
            r_d_lo   <= LO_W'(lo_full >> RCP_SHIFT);
            r_d_extm <= r_c_extm;
            r_d_rest <= (ACC_W'(r_c_rem) * ACC_W'(STEP_METRES)) << FRAC_BITS;
        end
        if (rdy_e) begin
            r_e_work.opcode   <= r_d_ctl.opcode;
            r_e_work.moving   <= r_d_ctl.moving;
            r_e_work.load     <= r_d_ctl.load;
            r_e_work.dist_fx  <= dist_sum[D_W-1:0];
            r_e_work.dist_ext <= dist_sum + (ACC_W'(r_d_extm) << FRAC_BITS);
            r_e_work.rest     <= r_d_rest;
        end
    end

endmodule

/* rtl/otrip_state.sv */
// Accumulator, trip and odometer state with the result register.
module otrip_state
    import otrip_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  t_work               i_work,
    output logic                o_ready,
    input  logic [TRIP_W-1:0]   i_trip_limit,
    input  logic [ODO_W-1:0]    i_odo_limit,
    output logic                o_valid,
    output t_result             o_result,
    input  logic                i_ready
);

    logic [ACC_W-1:0]   r_hacc, n_hacc;
    logic [ACC_W-1:0]   r_kacc, n_kacc;
    logic [TRIP_W-1:0]  r_trip1, n_trip1;
    logic [TRIP_W-1:0]  r_trip2, n_trip2;
    logic [ODO_W-1:0]   r_odo, n_odo;
    logic [CNT_W-1:0]   r_avg, n_avg;
    logic [CNT_W-1:0]   r_run, n_run;
    logic               r_out_v;
    t_result            r_out, n_out;

    logic               fire;
    logic [ACC_W:0]     h_sum, k_sum;
    logic [ACC_W-1:0]   h_new, k_new;
    logic [TRIP_W:0]    t1, t2;
    logic [ODO_W:0]     odo_inc;
    logic               trip_req, odo_req;

    assign o_ready  = !r_out_v || i_ready;
    assign fire     = i_valid && o_ready;
    assign o_valid  = r_out_v;
    assign o_result = r_out;

    always_comb begin
        n_hacc   = r_hacc;
        n_kacc   = r_kacc;
        n_trip1  = r_trip1;
        n_trip2  = r_trip2;
        n_odo    = r_odo;
        n_avg    = r_avg;
        n_run    = r_run;
        trip_req = 1'b0;
        odo_req  = 1'b0;
        h_sum    = {1'b0, r_hacc} + (ACC_W+1)'(i_work.dist_fx);
        k_sum    = {1'b0, r_kacc} + {1'b0, i_work.dist_ext};
        h_new    = h_sum[ACC_W] ? ACC_MAX : h_sum[ACC_W-1:0];
        k_new    = k_sum[ACC_W] ? ACC_MAX : k_sum[ACC_W-1:0];
        t1       = {1'b0, r_trip1} + 1'b1;
        t2       = {1'b0, r_trip2} + 1'b1;
        odo_inc  = {1'b0, r_odo} + 1'b1;

        unique case (i_work.opcode)
            OP_TICK: begin
                if (i_work.moving) begin
                    // at most one 100 m step per tick
                    if (h_new >= STEP_FX) begin
                        h_new   = h_new - STEP_FX;
                        n_avg   = (r_avg >= AVG_MAX) ? AVG_MAX : r_avg + 1'b1;
                        n_run   = r_run + 1'b1;
                        n_trip1 = t1[TRIP_W-1:0];
                        n_trip2 = t2[TRIP_W-1:0];
                        if (t1 >= {1'b0, i_trip_limit}) begin
                            n_trip1 = '0;
                            h_new   = '0;
                            k_new   = '0;
                        end
                        if (t2 >= {1'b0, i_trip_limit}) begin
                            n_trip2 = '0;
                            h_new   = '0;
                            k_new   = '0;
                        end
                        trip_req = 1'b1;
                    end
                    // at most one km step per tick; all ones freezes the odometer
                    if (k_new >= KM_FX) begin
                        k_new = k_new - KM_FX;
                        if (r_odo != ODO_INVALID) begin
                            if (odo_inc > {1'b0, i_odo_limit}) begin
                                n_odo = i_odo_limit;
                            end else begin
                                n_odo   = odo_inc[ODO_W-1:0];
                                odo_req = 1'b1;
                            end
                        end
                    end
                    n_hacc = h_new;
                    n_kacc = k_new;
                end
            end
            OP_CLR_TRIP1: begin
                n_trip1  = '0;
                n_hacc   = '0;
                n_kacc   = '0;
                trip_req = 1'b1;
            end
            OP_CLR_TRIP2: begin
                n_trip2 = '0;
                n_hacc  = '0;
                n_kacc  = '0;
            end
            OP_CLR_ODO: begin
                n_odo   = '0;
                n_kacc  = '0;
                odo_req = 1'b1;
            end
            OP_LOAD_ODO: begin
                n_odo = i_work.load[ODO_W-1:0];
            end
            OP_LOAD_TRIP1: begin
                n_trip1 = i_work.load[TRIP_W-1:0];
                n_kacc  = i_work.rest;
            end
            OP_LOAD_TRIP2: begin
                n_trip2 = i_work.load[TRIP_W-1:0];
                n_kacc  = i_work.rest;
            end
            default: begin
            end
        endcase

        n_out.trip_one           = n_trip1;
        n_out.trip_two           = n_trip2;
        n_out.odometer_km        = n_odo;
        n_out.fuel_avg_distance  = n_avg;
        n_out.this_trip_distance = n_run;
        n_out.trip_store_request = trip_req;
        n_out.odo_store_request  = odo_req;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hacc  <= '0;
            r_kacc  <= '0;
            r_trip1 <= '0;
            r_trip2 <= '0;
            r_odo   <= '0;
            r_avg   <= '0;
            r_run   <= '0;
            r_out_v <= 1'b0;
        end else begin
            if (fire) begin
                r_hacc  <= n_hacc;
                r_kacc  <= n_kacc;
                r_trip1 <= n_trip1;
                r_trip2 <= n_trip2;
                r_odo   <= n_odo;
                r_avg   <= n_avg;
                r_run   <= n_run;
            end
            if (o_ready) r_out_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) r_out <= n_out;
    end

endmodule

/* rtl/odometer_trip_accumulator_core.sv */
// Top level of the odometer and trip accumulator: stream ports and configuration registers.
//
// Takes one request per clock while the output is not stalled and returns one result per
// request, in order, showing the trip counters, odometer and distance counters after that
// request. Five registered stages turn speed and elapsed time into metres (product,
// division by 360 through a reciprocal multiply, sum), and the state stage updates the
// accumulators and counters and loads the result register. The state stage takes one
// request per cycle while the result stream is not stalled. The input side stays ready while
// results wait, until the pipeline is full. Configuration writes are always accepted and
// must only happen while no request is in flight. There is no clearing pass after reset.
module odometer_trip_accumulator_core
    import otrip_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // request stream
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    // speed[15:0], elapsed_ms[25:16], ignition_on[26], extra_hundreds[34:27],
    // load_value[66:35], zero padding above
    input  logic [IN_TDATA_W-1:0]   s_axis_tdata,
    // opcode[2:0]
    input  logic [OP_W-1:0]         s_axis_tuser,
    // result stream
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    // trip_one[15:0], trip_two[31:16], odometer_km[63:32], fuel_avg_distance[95:64],
    // this_trip_distance[127:96], trip_store_request[128], odo_store_request[129],
    // zero padding above
    output logic [OUT_TDATA_W-1:0]  m_axis_tdata,
    // configuration writes
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic                    i_cfg_index,
    input  logic [CFG_DATA_W-1:0]   i_cfg_data
);

    logic [TRIP_W-1:0]  r_trip_limit;
    logic [ODO_W-1:0]   r_odo_limit;

    t_req       req;
    logic       work_valid, work_ready;
    t_work      work;
    t_result    result;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_trip_limit <= TRIP_LIMIT_RST;
            r_odo_limit  <= ODO_LIMIT_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_TRIP_LIMIT: r_trip_limit <= i_cfg_data[TRIP_W-1:0];
                CFG_ODO_LIMIT:  r_odo_limit  <= i_cfg_data[ODO_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign req.opcode  = t_opcode'(s_axis_tuser);
    assign req.speed   = s_axis_tdata[15:0];
    assign req.elapsed = s_axis_tdata[25:16];
    assign req.ign     = s_axis_tdata[26];
    assign req.extra   = s_axis_tdata[34:27];
    assign req.load    = s_axis_tdata[66:35];

    otrip_dist u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .i_req   (req),
        .o_ready (s_axis_tready),
        .o_valid (work_valid),
        .o_work  (work),
        .i_ready (work_ready)
    );

    otrip_state u_state (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (work_valid),
        .i_work       (work),
        .o_ready      (work_ready),
        .i_trip_limit (r_trip_limit),
        .i_odo_limit  (r_odo_limit),
        .o_valid      (m_axis_tvalid),
        .o_result     (result),
        .i_ready      (m_axis_tready)
    );

    assign m_axis_tdata = {
        (OUT_TDATA_W-OUT_FIELDS_W)'(0),
        result.odo_store_request,
        result.trip_store_request,
        result.this_trip_distance,
        result.fuel_avg_distance,
        result.odometer_km,
        result.trip_two,
        result.trip_one
    };

    // average-fuel distance saturates one below all ones
    a_avg_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[95:64] != ~AVG_MAX + AVG_MAX))
        else $error("fuel average distance reached all ones");

    // an odometer store request never carries a value above the limit
    a_odo_req_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[129]) |-> (m_axis_tdata[63:32] <= r_odo_limit))
        else $error("odometer store request above limit");

    // with the result register empty the whole pipeline can take a request
    a_ready_when_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!m_axis_tvalid && !work_valid) |-> s_axis_tready)
        else $error("input stalled with empty output");

    // a store request for trip one follows only a tick or a trip one clear
    a_trip_req_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (work_valid && work_ready && work.opcode != OP_TICK
            && work.opcode != OP_CLR_TRIP1) |=> !m_axis_tdata[128])
        else $error("unexpected trip store request");

endmodule
